>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the tile map collision resolver RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tmbc_pkg.sv
// Shared constants, codes and types of the tile map collision resolver.
// Used by tmbc_span, tmbc_push and the top level; depends on nothing.
package tmbc_pkg;

  // Field widths
  localparam int POS_W  = 16;
  localparam int SIZE_W = 10;
  localparam int CODE_W = 8;
  localparam int TCOL_W = 7;
  localparam int TROW_W = 5;
  localparam int EDGE_W = POS_W + 1;

  // Tile geometry; the tile edge in fixed-point units is a power of two
  localparam int TILE_PIXELS   = 16;
  localparam int FRACTION_BITS = 4;
  localparam int TILE_UNITS    = TILE_PIXELS << FRACTION_BITS;
  localparam int TILE_SHIFT    = $clog2(TILE_UNITS);

  // Map defaults
  localparam int MAP_COLUMNS = 128;
  localparam int MAP_ROWS    = 32;

  // Item opcodes
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // Configuration register indexes
  localparam logic REG_EMPTY_CODE    = 1'b0;
  localparam logic REG_NONSOLID_CODE = 1'b1;

  // Outcome of testing the box against one tile
  typedef struct packed {
    logic                     hit;
    logic                     kill_vx;
    logic                     kill_vy;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
  } push_t;

endpackage

>>> rtl/tmbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No reset on contents; depends on nothing.
module tmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tmbc_span.sv
// Tile span along one axis: floor of both box edges, clamped to the map.
// Depends on tmbc_pkg.
module tmbc_span #(
  parameter int LIMIT = 128,
  parameter int IDX_W = 7
) (
  input  logic signed [tmbc_pkg::POS_W-1:0]  lo,
  input  logic        [tmbc_pkg::SIZE_W-1:0] size,
  output logic        [IDX_W-1:0]            first,
  output logic        [IDX_W-1:0]            last,
  output logic                               empty
);

  localparam int EW = tmbc_pkg::EDGE_W;
  localparam logic signed [EW-1:0] LAST_IDX = EW'(LIMIT - 1);

  logic signed [EW-1:0] lo_ext;
  logic signed [EW-1:0] hi;
  logic signed [EW-1:0] f_raw;
  logic signed [EW-1:0] l_raw;
  logic signed [EW-1:0] f_cl;
  logic signed [EW-1:0] l_cl;

  // Edges and their tile indexes (arithmetic shift floors toward minus infinity)
  assign lo_ext = {lo[tmbc_pkg::POS_W-1], lo};
  assign hi     = lo_ext + EW'(size);
  assign f_raw  = lo_ext >>> tmbc_pkg::TILE_SHIFT;
  assign l_raw  = hi >>> tmbc_pkg::TILE_SHIFT;

  // Clamp to the map; an inverted span visits nothing
  always_comb begin
    f_cl  = f_raw[EW-1] ? '0 : f_raw;
    l_cl  = (l_raw > LAST_IDX) ? LAST_IDX : l_raw;
    empty = f_cl > l_cl;
    first = f_cl[IDX_W-1:0];
    last  = l_cl[IDX_W-1:0];
  end

endmodule

>>> rtl/tmbc_push.sv
// Box against one tile: overlap test, smallest penetration, push and saturate.
// Depends on tmbc_pkg (push_t, widths, tile geometry).
module tmbc_push #(
  parameter int COL_W  = 7,
  parameter int ROW_W  = 5,
  parameter int CALC_W = 18
) (
  input  logic signed [tmbc_pkg::POS_W-1:0]  x,
  input  logic signed [tmbc_pkg::POS_W-1:0]  y,
  input  logic        [tmbc_pkg::SIZE_W-1:0] w,
  input  logic        [tmbc_pkg::SIZE_W-1:0] h,
  input  logic        [COL_W-1:0]            col,
  input  logic        [ROW_W-1:0]            row,
  input  logic        [tmbc_pkg::CODE_W-1:0] code,
  input  logic        [tmbc_pkg::CODE_W-1:0] empty_code,
  input  logic        [tmbc_pkg::CODE_W-1:0] nonsolid_code,
  output tmbc_pkg::push_t                    res
);

  localparam int PW = tmbc_pkg::POS_W;
  localparam logic signed [CALC_W-1:0] TU      = CALC_W'(tmbc_pkg::TILE_UNITS);
  localparam logic signed [CALC_W-1:0] POS_MAX = CALC_W'(32767);
  localparam logic signed [CALC_W-1:0] POS_MIN = CALC_W'(-32768);

  logic signed [CALC_W-1:0] xs, ys, ws, hs, tx, ty, xr, yb, txe, tye;
  logic signed [CALC_W-1:0] pl, pr, pt, pb;
  logic solid, over, sel_l, sel_r, sel_t;

  // Clip a pushed edge to the 16-bit position range
  function automatic logic signed [PW-1:0] sat(input logic signed [CALC_W-1:0] v);
    logic signed [PW-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[PW-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[PW-1:0];
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  // Box and tile edges
  assign xs  = CALC_W'(x);
  assign ys  = CALC_W'(y);
  assign ws  = CALC_W'(w);
  assign hs  = CALC_W'(h);
  assign tx  = CALC_W'(col) << tmbc_pkg::TILE_SHIFT;
  assign ty  = CALC_W'(row) << tmbc_pkg::TILE_SHIFT;
  assign xr  = xs + ws;
  assign yb  = ys + hs;
  assign txe = tx + TU;
  assign tye = ty + TU;

  // Strict overlap with a solid tile
  assign solid = (code != empty_code) && (code != nonsolid_code);
  assign over  = solid && (xs < txe) && (xr > tx) && (ys < tye) && (yb > ty);

  // Penetration depths; ties go left, right, top, bottom
  assign pl    = xr - tx;
  assign pr    = txe - xs;
  assign pt    = yb - ty;
  assign pb    = tye - ys;
  assign sel_l = (pl <= pr) && (pl <= pt) && (pl <= pb);
  assign sel_r = !sel_l && (pr <= pt) && (pr <= pb);
  assign sel_t = !sel_l && !sel_r && (pt <= pb);

  // Push out along the chosen side
  always_comb begin
    res.hit     = over;
    res.kill_vx = 1'b0;
    res.kill_vy = 1'b0;
    res.x       = x;
    res.y       = y;
    if (over) begin
      if (sel_l) begin
        res.x       = sat(tx - ws);
        res.kill_vx = 1'b1;
      end else if (sel_r) begin
        res.x       = sat(txe);
        res.kill_vx = 1'b1;
      end else if (sel_t) begin
        res.y       = sat(ty - hs);
        res.kill_vy = 1'b1;
      end else begin
        res.y       = sat(tye);
        res.kill_vy = 1'b1;
      end
    end
  end

endmodule

>>> rtl/tile_map_box_collision_resolver_unit.sv
// Tile map box collision resolver: tile memory, span sequencer and output register.
// A resolve beat computes its span, then reads and resolves the N tiles of the clamped span,
// one tile read per cycle, N being up to 25 for a 64-pixel box; an empty span skips the walk.
// A tile write leaves the input free for the next item; a resolve stalls the input until
// its result is loaded, waiting while an output beat is held. One item is in work at a time.
// Reset clears control state, sets empty_code to 0 and nonsolid_code to 1; tiles are kept.
`include "assert_macros.svh"

module tile_map_box_collision_resolver_unit #(
  parameter int MAP_COLUMNS = tmbc_pkg::MAP_COLUMNS,
  parameter int MAP_ROWS    = tmbc_pkg::MAP_ROWS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic        [tmbc_pkg::CODE_W-1:0] cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic        [tmbc_pkg::TCOL_W-1:0] tile_col,
  input  logic        [tmbc_pkg::TROW_W-1:0] tile_row,
  input  logic        [tmbc_pkg::CODE_W-1:0] tile_code,
  input  logic signed [tmbc_pkg::POS_W-1:0]  entity_x,
  input  logic signed [tmbc_pkg::POS_W-1:0]  entity_y,
  input  logic        [tmbc_pkg::SIZE_W-1:0] entity_w,
  input  logic        [tmbc_pkg::SIZE_W-1:0] entity_h,
  input  logic signed [tmbc_pkg::POS_W-1:0]  vel_x,
  input  logic signed [tmbc_pkg::POS_W-1:0]  vel_y,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tmbc_pkg::POS_W-1:0]  out_x,
  output logic signed [tmbc_pkg::POS_W-1:0]  out_y,
  output logic signed [tmbc_pkg::POS_W-1:0]  out_vel_x,
  output logic signed [tmbc_pkg::POS_W-1:0]  out_vel_y,
  output logic                               collided
);

  localparam int PW     = tmbc_pkg::POS_W;
  localparam int COL_W  = (MAP_COLUMNS > 1) ? $clog2(MAP_COLUMNS) : 1;
  localparam int ROW_W  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int DEPTH  = MAP_COLUMNS * MAP_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CALC_W = (IDX_W + tmbc_pkg::TILE_SHIFT + 3 > PW + 2) ?
                          IDX_W + tmbc_pkg::TILE_SHIFT + 3 : PW + 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SPAN = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state;

  logic [tmbc_pkg::CODE_W-1:0] empty_code;
  logic [tmbc_pkg::CODE_W-1:0] nonsolid_code;

  // Working box and velocity
  logic signed [PW-1:0]              x, y, vx, vy;
  logic [tmbc_pkg::SIZE_W-1:0]       w, h;
  logic                              hit;

  // Span bounds and walk position
  logic [COL_W-1:0] c0, c1, c, rd_col;
  logic [ROW_W-1:0] r1, r, rd_row;
  logic             issue_done;
  logic             rd_pend;

  logic [COL_W-1:0] col_first, col_last;
  logic [ROW_W-1:0] row_first, row_last;
  logic             col_empty, row_empty;

  logic                        in_beat;
  logic                        wr_in_map;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [tmbc_pkg::CODE_W-1:0] ram_rdata;
  tmbc_pkg::push_t             push;

  assign in_stall = (state != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;

  // Tile writes land straight in memory; writes off the map are dropped
  assign wr_in_map = (32'(tile_col) < MAP_COLUMNS) && (32'(tile_row) < MAP_ROWS);
  assign ram_we    = in_beat && (opcode == tmbc_pkg::OP_WRITE) && wr_in_map;
  assign ram_waddr = ADDR_W'(32'(tile_row) * 32'(MAP_COLUMNS) + 32'(tile_col));
  assign ram_raddr = ADDR_W'(32'(r) * 32'(MAP_COLUMNS) + 32'(c));

  // Reads happen only while walking a span, writes only when idle: no overlap
  tmbc_ram #(
    .WIDTH (tmbc_pkg::CODE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_tiles (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(tile_code),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tmbc_span #(.LIMIT(MAP_COLUMNS), .IDX_W(COL_W)) u_col_span (
    .lo(x), .size(w), .first(col_first), .last(col_last), .empty(col_empty)
  );

  tmbc_span #(.LIMIT(MAP_ROWS), .IDX_W(ROW_W)) u_row_span (
    .lo(y), .size(h), .first(row_first), .last(row_last), .empty(row_empty)
  );

  tmbc_push #(.COL_W(COL_W), .ROW_W(ROW_W), .CALC_W(CALC_W)) u_push (
    .x(x), .y(y), .w(w), .h(h), .col(rd_col), .row(rd_row), .code(ram_rdata),
    .empty_code(empty_code), .nonsolid_code(nonsolid_code), .res(push)
  );

  // Sequencer: take beat, compute span, stream reads and resolve, hand off result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      rd_pend       <= 1'b0;
      empty_code    <= '0;
      nonsolid_code <= tmbc_pkg::CODE_W'(1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tmbc_pkg::REG_EMPTY_CODE:    empty_code    <= cfg_data;
          tmbc_pkg::REG_NONSOLID_CODE: nonsolid_code <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once taken, unless the next one loads in its place
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_beat && (opcode == tmbc_pkg::OP_RESOLVE)) begin
            x     <= entity_x;
            y     <= entity_y;
            w     <= entity_w;
            h     <= entity_h;
            vx    <= vel_x;
            vy    <= vel_y;
            hit   <= 1'b0;
            state <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          if (col_empty || row_empty) begin
            state <= ST_FIN;
          end else begin
            c0         <= col_first;
            c1         <= col_last;
            r1         <= row_last;
            c          <= col_first;
            r          <= row_first;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          // Issue the next read and advance the walk, row by row
          rd_pend <= !issue_done;
          rd_col  <= c;
          rd_row  <= r;
          if (!issue_done) begin
            if (c == c1) begin
              c <= c0;
              if (r == r1) begin
                issue_done <= 1'b1;
              end else begin
                r <= r + ROW_W'(1);
              end
            end else begin
              c <= c + COL_W'(1);
            end
          end
          // Resolve the tile whose code just came back
          if (rd_pend) begin
            x <= push.x;
            y <= push.y;
            if (push.kill_vx) begin
              vx <= '0;
            end
            if (push.kill_vy) begin
              vy <= '0;
            end
            if (push.hit) begin
              hit <= 1'b1;
            end
          end
          if (issue_done && !rd_pend) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Load the output register once it is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_x     <= x;
            out_y     <= y;
            out_vel_x <= vx;
            out_vel_y <= vy;
            collided  <= hit;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A code comes back only while walking a span
  `ASSERT_IMPLIES(a_read_in_run, rd_pend, state == ST_RUN, "tile read outside span walk")
  // The walk stays inside the clamped span
  `ASSERT_IMPLIES(a_walk_in_span, (state == ST_RUN) && !issue_done,
                  (r <= r1) && (c >= c0) && (c <= c1), "walk left the span")
  // A resolve beat starts the span step
  `ASSERT_NEXT(a_resolve_starts, in_beat && (opcode == tmbc_pkg::OP_RESOLVE),
               state == ST_SPAN, "resolve beat did not start span")
  // A finished result waits while the output register is held
  `ASSERT_NEXT(a_fin_waits, (state == ST_FIN) && out_valid && out_stall,
               state == ST_FIN, "result overwrote a held beat")

endmodule

>>> tb/tb.sv
// Self-checking testbench for tile_map_box_collision_resolver_unit.
// Depends on tmbc_pkg and the block's RTL; a scoreboard class predicts every resolve
// beat, and random stimulus with idles and stalls runs across several code settings.
module tb;

  localparam int POS_W       = tmbc_pkg::POS_W;
  localparam int SIZE_W      = tmbc_pkg::SIZE_W;
  localparam int CODE_W      = tmbc_pkg::CODE_W;
  localparam int TCOL_W      = tmbc_pkg::TCOL_W;
  localparam int TROW_W      = tmbc_pkg::TROW_W;
  localparam int TILE_UNITS  = tmbc_pkg::TILE_UNITS;
  localparam int TILE_SHIFT  = tmbc_pkg::TILE_SHIFT;
  localparam int MAP_COLUMNS = tmbc_pkg::MAP_COLUMNS;
  localparam int MAP_ROWS    = tmbc_pkg::MAP_ROWS;

  localparam int MAP_TILES = MAP_COLUMNS * MAP_ROWS;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic                     opcode;
    logic [TCOL_W-1:0]        col;
    logic [TROW_W-1:0]        row;
    logic [CODE_W-1:0]        code;
    logic signed [POS_W-1:0]  ex;
    logic signed [POS_W-1:0]  ey;
    logic [SIZE_W-1:0]        ew;
    logic [SIZE_W-1:0]        eh;
    logic signed [POS_W-1:0]  vx;
    logic signed [POS_W-1:0]  vy;
  } tile_beat_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic                    hit;
  } resolved_t;

  // Tracks the tile map and code registers, predicts each resolve, checks out beats
  class resolver_scoreboard;
    logic [CODE_W-1:0] tile_map [MAP_TILES];
    logic [CODE_W-1:0] empty_code_q;
    logic [CODE_W-1:0] nonsolid_code_q;
    resolved_t         resolved_q [$];
    int                writes_seen;
    int                resolves_seen;
    int                hits_seen;
    int                faults;

    function new();
      empty_code_q = 8'd0;
      nonsolid_code_q = 8'd1;
    endfunction

    function void set_code(logic idx, logic [CODE_W-1:0] value);
      if (idx == tmbc_pkg::REG_EMPTY_CODE) empty_code_q = value;
      else nonsolid_code_q = value;
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Tiles under the box, clamped to the map; the far edge counts as inside
    function void tile_span(int ex, int ey, int ew, int eh,
                            output int c0, output int c1, output int r0, output int r1);
      c0 = ex >>> TILE_SHIFT;
      c1 = (ex + ew) >>> TILE_SHIFT;
      r0 = ey >>> TILE_SHIFT;
      r1 = (ey + eh) >>> TILE_SHIFT;
      if (c0 < 0) c0 = 0;
      if (r0 < 0) r0 = 0;
      if (c1 > MAP_COLUMNS - 1) c1 = MAP_COLUMNS - 1;
      if (r1 > MAP_ROWS - 1) r1 = MAP_ROWS - 1;
    endfunction

    // Push the box out of each solid tile in scan order, along the side of smallest penetration
    function resolved_t resolve_box(tile_beat_t b);
      int ex, ey, ew, eh, c0, c1, r0, r1, tx, ty, pl, pr, pt, pb, m;
      logic [CODE_W-1:0] code;
      resolved_t res;
      ex = int'(b.ex);
      ey = int'(b.ey);
      ew = int'(b.ew);
      eh = int'(b.eh);
      res.vx = b.vx;
      res.vy = b.vy;
      res.hit = 1'b0;
      tile_span(ex, ey, ew, eh, c0, c1, r0, r1);
      for (int r = r0; r <= r1; r++) begin
        for (int c = c0; c <= c1; c++) begin
          code = tile_map[r * MAP_COLUMNS + c];
          tx = c * TILE_UNITS;
          ty = r * TILE_UNITS;
          if (code != empty_code_q && code != nonsolid_code_q &&
              ex < tx + TILE_UNITS && ex + ew > tx &&
              ey < ty + TILE_UNITS && ey + eh > ty) begin
            res.hit = 1'b1;
            pl = (ex + ew) - tx;
            pr = (tx + TILE_UNITS) - ex;
            pt = (ey + eh) - ty;
            pb = (ty + TILE_UNITS) - ey;
            m = pl;
            if (pr < m) m = pr;
            if (pt < m) m = pt;
            if (pb < m) m = pb;
            if (m == pl) begin
              ex = clamp16(tx - ew);
              res.vx = '0;
            end else if (m == pr) begin
              ex = clamp16(tx + TILE_UNITS);
              res.vx = '0;
            end else if (m == pt) begin
              ey = clamp16(ty - eh);
              res.vy = '0;
            end else begin
              ey = clamp16(ty + TILE_UNITS);
              res.vy = '0;
            end
          end
        end
      end
      res.x = POS_W'(ex);
      res.y = POS_W'(ey);
      return res;
    endfunction

    function void note_beat(tile_beat_t b);
      resolved_t res;
      if (b.opcode == tmbc_pkg::OP_WRITE) begin
        tile_map[int'(b.row) * MAP_COLUMNS + int'(b.col)] = b.code;
        writes_seen++;
      end else begin
        res = resolve_box(b);
        resolved_q.push_back(res);
        resolves_seen++;
        if (res.hit) hits_seen++;
      end
    endfunction

    function void check_result(resolved_t got);
      resolved_t want;
      if (resolved_q.size() == 0) begin
        $error("out beat with no resolve pending: x %0d y %0d", got.x, got.y);
        faults++;
        return;
      end
      want = resolved_q.pop_front();
      if (got.x !== want.x) begin
        $error("out_x: expected %0d, got %0d", want.x, got.x);
        faults++;
      end
      if (got.y !== want.y) begin
        $error("out_y: expected %0d, got %0d", want.y, got.y);
        faults++;
      end
      if (got.vx !== want.vx) begin
        $error("out_vel_x: expected %0d, got %0d", want.vx, got.vx);
        faults++;
      end
      if (got.vy !== want.vy) begin
        $error("out_vel_y: expected %0d, got %0d", want.vy, got.vy);
        faults++;
      end
      if (got.hit !== want.hit) begin
        $error("collided: expected %0b, got %0b", want.hit, got.hit);
        faults++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CODE_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     opcode;
  logic [TCOL_W-1:0]        tile_col;
  logic [TROW_W-1:0]        tile_row;
  logic [CODE_W-1:0]        tile_code;
  logic signed [POS_W-1:0]  entity_x;
  logic signed [POS_W-1:0]  entity_y;
  logic [SIZE_W-1:0]        entity_w;
  logic [SIZE_W-1:0]        entity_h;
  logic signed [POS_W-1:0]  vel_x;
  logic signed [POS_W-1:0]  vel_y;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [POS_W-1:0]  out_x;
  logic signed [POS_W-1:0]  out_y;
  logic signed [POS_W-1:0]  out_vel_x;
  logic signed [POS_W-1:0]  out_vel_y;
  logic                     collided;

  resolver_scoreboard sb = new();
  bit tile_known [MAP_TILES];
  bit calm;
  bit hold_off_req;
  int beats_sent;
  int settings_run;

  tile_map_box_collision_resolver_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .tile_col(tile_col), .tile_row(tile_row), .tile_code(tile_code),
    .entity_x(entity_x), .entity_y(entity_y), .entity_w(entity_w), .entity_h(entity_h),
    .vel_x(vel_x), .vel_y(vel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_vel_x(out_vel_x), .out_vel_y(out_vel_y),
    .collided(collided)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #1_200_000;
    $display("TB_ERROR");
    $finish;
  end

  // Output side: check accepted beats, stall at random or for a long hold-off
  initial begin : sink
    int hold_left;
    resolved_t got;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.x = out_x;
        got.y = out_y;
        got.vx = out_vel_x;
        got.vy = out_vel_y;
        got.hit = collided;
        sb.check_result(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 12);
      end
    end
  end

  function automatic tile_beat_t noise_beat();
    tile_beat_t b;
    b.opcode = 1'($urandom_range(1));
    b.col = TCOL_W'($urandom);
    b.row = TROW_W'($urandom);
    b.code = CODE_W'($urandom);
    b.ex = POS_W'($urandom);
    b.ey = POS_W'($urandom);
    b.ew = SIZE_W'($urandom);
    b.eh = SIZE_W'($urandom);
    b.vx = POS_W'($urandom);
    b.vy = POS_W'($urandom);
    return b;
  endfunction

  function automatic tile_beat_t tile_wr(int c, int r, logic [CODE_W-1:0] code);
    tile_beat_t b;
    b = noise_beat();
    b.opcode = tmbc_pkg::OP_WRITE;
    b.col = TCOL_W'(c);
    b.row = TROW_W'(r);
    b.code = code;
    return b;
  endfunction

  function automatic tile_beat_t box(int ex, int ey, int ew, int eh, int vx, int vy);
    tile_beat_t b;
    b = noise_beat();
    b.opcode = tmbc_pkg::OP_RESOLVE;
    b.ex = POS_W'(ex);
    b.ey = POS_W'(ey);
    b.ew = SIZE_W'(ew);
    b.eh = SIZE_W'(eh);
    b.vx = POS_W'(vx);
    b.vy = POS_W'(vy);
    return b;
  endfunction

  // Favor the live empty and nonsolid codes so skips happen often
  function automatic logic [CODE_W-1:0] pick_code();
    int k;
    k = $urandom_range(99);
    if (k < 35) return sb.empty_code_q;
    if (k < 50) return sb.nonsolid_code_q;
    if (k < 55) return 8'd0;
    if (k < 60) return 8'd255;
    return CODE_W'($urandom);
  endfunction

  function automatic int pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 55) return $urandom_range(300);
    if (k < 85) return $urandom_range(1023);
    case ($urandom_range(3))
      0: return 0;
      1: return 1023;
      2: return 256;
      default: return 1;
    endcase
  endfunction

  // Drive one beat after an optional idle gap; hold it until accepted
  task automatic send_beat(input tile_beat_t b);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= b.opcode;
    tile_col <= b.col;
    tile_row <= b.row;
    tile_code <= b.code;
    entity_x <= b.ex;
    entity_y <= b.ey;
    entity_w <= b.ew;
    entity_h <= b.eh;
    vel_x <= b.vx;
    vel_y <= b.vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b);
    if (b.opcode == tmbc_pkg::OP_WRITE) begin
      tile_known[int'(b.row) * MAP_COLUMNS + int'(b.col)] = 1'b1;
    end
    beats_sent++;
  endtask

  // Write any tile under a resolve box that was never written, then send the beat
  task automatic offer(input tile_beat_t b);
    int c0, c1, r0, r1;
    if (b.opcode == tmbc_pkg::OP_RESOLVE) begin
      sb.tile_span(int'(b.ex), int'(b.ey), int'(b.ew), int'(b.eh), c0, c1, r0, r1);
      for (int r = r0; r <= r1; r++) begin
        for (int c = c0; c <= c1; c++) begin
          if (!tile_known[r * MAP_COLUMNS + c]) send_beat(tile_wr(c, r, pick_code()));
        end
      end
    end
    send_beat(b);
  endtask

  // Stop offering, wait out every pending result, then let the block go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.resolved_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_codes(input logic [CODE_W-1:0] empty_v,
                               input logic [CODE_W-1:0] nonsolid_v);
    cfg_we <= 1'b1;
    cfg_index <= tmbc_pkg::REG_EMPTY_CODE;
    cfg_data <= empty_v;
    @(posedge clk);
    sb.set_code(tmbc_pkg::REG_EMPTY_CODE, empty_v);
    cfg_index <= tmbc_pkg::REG_NONSOLID_CODE;
    cfg_data <= nonsolid_v;
    @(posedge clk);
    sb.set_code(tmbc_pkg::REG_NONSOLID_CODE, nonsolid_v);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Mostly writes and boxes around the top-left or bottom-right map corner, some fully random beats
  task automatic random_item();
    tile_beat_t b;
    int sel, c, r, ew, eh;
    b = noise_beat();
    sel = $urandom_range(99);
    if ($urandom_range(1)) begin
      c = $urandom_range(11);
      r = $urandom_range(7);
    end else begin
      c = $urandom_range(127, 116);
      r = $urandom_range(31, 24);
    end
    if (sel < 28) begin
      b = tile_wr(c, r, pick_code());
    end else if (sel < 32) begin
      b.opcode = tmbc_pkg::OP_WRITE;
      b.code = pick_code();
    end else if (sel < 80) begin
      ew = pick_size();
      eh = pick_size();
      b.opcode = tmbc_pkg::OP_RESOLVE;
      b.ew = SIZE_W'(ew);
      b.eh = SIZE_W'(eh);
      b.ex = POS_W'(sb.clamp16(c * TILE_UNITS - ew - 50 +
                               int'($urandom_range(ew + TILE_UNITS + 100))));
      b.ey = POS_W'(sb.clamp16(r * TILE_UNITS - eh - 50 +
                               int'($urandom_range(eh + TILE_UNITS + 100))));
    end else begin
      b.opcode = tmbc_pkg::OP_RESOLVE;
    end
    offer(b);
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0] empty_v, nonsolid_v;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= tmbc_pkg::REG_EMPTY_CODE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= tmbc_pkg::OP_WRITE;
    tile_col <= '0;
    tile_row <= '0;
    tile_code <= '0;
    entity_x <= '0;
    entity_y <= '0;
    entity_w <= '0;
    entity_h <= '0;
    vel_x <= '0;
    vel_y <= '0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one solid tile with a nonsolid neighbor, map corners at the far edges
    for (int r = 2; r <= 4; r++) begin
      for (int c = 4; c <= 6; c++) begin
        if (c == 5 && r == 3) offer(tile_wr(c, r, 8'h80));
        else if (c == 4 && r == 3) offer(tile_wr(c, r, 8'h01));
        else offer(tile_wr(c, r, 8'h00));
      end
    end
    offer(tile_wr(127, 0, 8'hFF));
    offer(tile_wr(127, 1, 8'h00));
    offer(tile_wr(126, 31, 8'h00));
    offer(tile_wr(127, 31, 8'hFF));
    // four-way tie goes left
    offer(box(1280, 768, 256, 256, 100, -100));
    // right, top and bottom pushes
    offer(box(1480, 818, 100, 100, 32767, 5));
    offer(box(1300, 668, 150, 140, -7, 32767));
    offer(box(1300, 968, 150, 100, 3, -32768));
    // edges that only touch, and a nonsolid tile
    offer(box(1180, 768, 100, 100, 11, 12));
    offer(box(1034, 800, 50, 50, 13, 14));
    // zero-size box inside a solid tile
    offer(box(1380, 868, 0, 0, 15, 16));
    // right push past the last column saturates
    offer(box(32700, 0, 100, 256, -1, 1));
    // span wholly outside the map
    offer(box(-32768, 32767, 1023, 1023, -32768, 32767));
    // largest box at the bottom right corner
    offer(box(32500, 7936, 1023, 1023, 200, 200));

    // Random phases, each under its own pair of codes
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin empty_v = 8'd0;   nonsolid_v = 8'd1;   end
        1: begin empty_v = 8'd255; nonsolid_v = 8'd254; end
        2: begin empty_v = 8'd0;   nonsolid_v = 8'd0;   end
        3: begin empty_v = 8'd255; nonsolid_v = 8'd255; end
        4: begin empty_v = CODE_W'($urandom); nonsolid_v = CODE_W'($urandom); end
        default: begin empty_v = 8'd7; nonsolid_v = 8'd0; end
      endcase
      program_codes(empty_v, nonsolid_v);
      calm = (p == 3);
      if (p == 2) hold_off_req = 1'b1;
      while (beats_sent < 23 + (p + 1) * 255) random_item();
    end
    calm = 1'b0;
    drain();

    $display("Ran %0d tile writes and %0d box resolves, %0d of them colliding,",
             sb.writes_seen, sb.resolves_seen, sb.hits_seen);
    $display("under %0d empty/nonsolid code settings with random idles and stalls.",
             settings_run);
    if (sb.faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/tmbc_pkg.sv
rtl/tmbc_ram.sv
rtl/tmbc_span.sv
rtl/tmbc_push.sv
rtl/tile_map_box_collision_resolver_unit.sv
tb/tb.sv
